// ----- hdl/slt_pkg.sv -----
package slt_pkg;

    localparam int POS_WIDTH     = 16;
    localparam int KEYWORD_CHARS = 8;
    localparam int WLEN_WIDTH    = $clog2(KEYWORD_CHARS + 2);
    localparam int NUM_KW        = 17;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_BANG    = 4'd1;
    localparam logic [3:0] M_EQ      = 4'd2;
    localparam logic [3:0] M_LT      = 4'd3;
    localparam logic [3:0] M_GT      = 4'd4;
    localparam logic [3:0] M_SLASH   = 4'd5;
    localparam logic [3:0] M_COMMENT = 4'd6;
    localparam logic [3:0] M_STRING  = 4'd7;
    localparam logic [3:0] M_INT     = 4'd8;
    localparam logic [3:0] M_DOT     = 4'd9;
    localparam logic [3:0] M_FRAC    = 4'd10;
    localparam logic [3:0] M_WORD    = 4'd11;

    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_BANG    = 6'd17;
    localparam logic [5:0] K_BANG_EQ = 6'd18;
    localparam logic [5:0] K_EQ      = 6'd19;
    localparam logic [5:0] K_EQ_EQ   = 6'd20;
    localparam logic [5:0] K_LT      = 6'd21;
    localparam logic [5:0] K_LT_EQ   = 6'd22;
    localparam logic [5:0] K_SHL     = 6'd23;
    localparam logic [5:0] K_GT      = 6'd24;
    localparam logic [5:0] K_GT_EQ   = 6'd25;
    localparam logic [5:0] K_SHR     = 6'd26;
    localparam logic [5:0] K_SLASH   = 6'd27;
    localparam logic [5:0] K_STRING  = 6'd28;
    localparam logic [5:0] K_NUMBER  = 6'd29;
    localparam logic [5:0] K_IDENT   = 6'd30;
    localparam logic [5:0] K_KW0     = 6'd31;
    localparam logic [5:0] K_END     = 6'd48;
    localparam logic [5:0] K_ERROR   = 6'd0;

    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM     = 2'd2;

    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;

    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'("if"), 64'("for"), 64'("fun"), 64'("and"), 64'("or"), 64'("nil"),
        64'("var"), 64'("else"), 64'("break"), 64'("continue"), 64'("this"),
        64'("true"), 64'("class"), 64'("false"), 64'("super"), 64'("while"),
        64'("return")
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd2, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3, 4'd3, 4'd4, 4'd5, 4'd8, 4'd4,
        4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] spos;
        logic [15:0] epos;
        logic [15:0] line;
        logic [1:0]  err;
        logic [7:0]  bad;
    } tok_t;

    typedef struct packed {
        logic [1:0]       cnt;
        tok_t [2:0]       toks;
    } entry_t;

    function automatic logic [5:0] single_kind(input logic [7:0] c, output logic hit);
        logic [5:0] k;
        hit = 1'b1;
        k   = 6'd0;
        unique case (c)
            8'h28: k = 6'd0;
            8'h29: k = 6'd1;
            8'h7b: k = 6'd2;
            8'h7d: k = 6'd3;
            8'h2c: k = 6'd4;
            8'h2e: k = 6'd5;
            8'h2d: k = 6'd6;
            8'h2b: k = 6'd7;
            8'h3b: k = 6'd8;
            8'h2a: k = 6'd9;
            8'h3f: k = 6'd10;
            8'h3a: k = 6'd11;
            8'h5e: k = 6'd12;
            8'h7e: k = 6'd13;
            8'h25: k = 6'd14;
            8'h26: k = 6'd15;
            8'h7c: k = 6'd16;
            default: hit = 1'b0;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] kw_lookup(input logic [63:0] w,
                                             input logic [WLEN_WIDTH-1:0] len);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 0; i < NUM_KW; i++)
            if (len == WLEN_WIDTH'(KW_LEN[i]) && w == KW_TEXT[i])
                k = K_KW0 + 6'(i);
        return k;
    endfunction

endpackage

// ----- hdl/slt_front.sv -----
module slt_front
    import slt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] char_code,
    input  logic       q_full,
    output logic       push,
    output entry_t     push_data
);

    logic [3:0]            mode_reg, mode_next;
    logic [POS_WIDTH-1:0]  tstart_reg, tstart_next;
    logic [POS_WIDTH-1:0]  pos_reg, pos_next;
    logic [POS_WIDTH-1:0]  line_reg, line_next;
    logic [WLEN_WIDTH-1:0] wlen_reg, wlen_next;
    logic [7:0]            wbytes_reg [KEYWORD_CHARS];
    logic                  wr_en;
    logic [WLEN_WIDTH-1:0] wr_idx;

    logic accept;
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) || c == 8'h5f;
    endfunction

    logic [63:0] word_packed;
    logic [5:0]  word_kind;

    always_comb
    begin
        word_packed = '0;
        for (int i = 0; i < 8; i++)
            if (i < KEYWORD_CHARS && WLEN_WIDTH'(i) < wlen_reg)
                word_packed = {word_packed[55:0], wbytes_reg[i]};
        word_kind = (wlen_reg > WLEN_WIDTH'(8)) ? K_IDENT : kw_lookup(word_packed, wlen_reg);
    end

    always_comb
    begin
        logic [POS_WIDTH-1:0] p;
        logic [POS_WIDTH-1:0] e;
        logic [POS_WIDTH-1:0] dotp;
        logic                 taken;
        logic [3:0]           cm;
        logic [1:0]           n;
        logic                 hit;
        logic [5:0]           sk;
        tok_t                 t;

        mode_next   = mode_reg;
        tstart_next = tstart_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        wlen_next   = wlen_reg;
        wr_en       = 1'b0;
        wr_idx      = wlen_reg;
        push_data   = '0;
        n           = 2'd0;
        taken       = 1'b0;
        cm          = mode_reg;
        p           = pos_reg;
        e           = sat_inc(pos_reg);
        dotp        = (pos_reg != '0) ? pos_reg - 1'b1 : '0;
        hit         = 1'b0;
        sk          = single_kind(char_code, hit);
        t           = '0;
        t.line      = 16'(line_reg);

        if (kind)
        begin
            t.epos = 16'(p);
            unique case (mode_reg)
                M_BANG, M_EQ, M_LT, M_GT, M_SLASH, M_INT, M_FRAC, M_WORD:
                begin
                    t.spos = 16'(tstart_reg);
                    unique case (mode_reg)
                        M_BANG:  t.kind = K_BANG;
                        M_EQ:    t.kind = K_EQ;
                        M_LT:    t.kind = K_LT;
                        M_GT:    t.kind = K_GT;
                        M_SLASH: t.kind = K_SLASH;
                        M_WORD:  t.kind = word_kind;
                        default: t.kind = K_NUMBER;
                    endcase
                    push_data.toks[n] = t;
                    n = n + 2'd1;
                end
                M_STRING:
                begin
                    t.spos = 16'(tstart_reg);
                    t.kind = K_ERROR;
                    t.err  = E_UNTERM;
                    push_data.toks[n] = t;
                    n = n + 2'd1;
                end
                M_DOT:
                begin
                    t.spos = 16'(tstart_reg);
                    t.epos = 16'(dotp);
                    t.kind = K_NUMBER;
                    push_data.toks[0] = t;
                    t.spos = 16'(dotp);
                    t.epos = 16'(p);
                    t.kind = K_DOT;
                    push_data.toks[1] = t;
                    n = 2'd2;
                end
                default: ;
            endcase
            t      = '0;
            t.line = 16'(line_reg);
            t.kind = K_END;
            t.spos = 16'(p);
            t.epos = 16'(p);
            push_data.toks[n] = t;
            n = n + 2'd1;
            mode_next   = M_IDLE;
            tstart_next = '0;
            pos_next    = '0;
            line_next   = POS_WIDTH'(1);
            wlen_next   = '0;
        end
        else
        begin
            t.spos = 16'(tstart_reg);
            t.epos = 16'(e);
            unique case (mode_reg)
                M_BANG, M_EQ:
                    if (char_code == CH_EQ)
                    begin
                        t.kind = (mode_reg == M_BANG) ? K_BANG_EQ : K_EQ_EQ;
                        push_data.toks[0] = t;
                        n = 2'd1;
                        taken = 1'b1;
                        mode_next = M_IDLE;
                    end
                M_LT, M_GT:
                    if (char_code == CH_EQ)
                    begin
                        t.kind = (mode_reg == M_LT) ? K_LT_EQ : K_GT_EQ;
                        push_data.toks[0] = t;
                        n = 2'd1;
                        taken = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else if (char_code == ((mode_reg == M_LT) ? CH_LT : CH_GT))
                    begin
                        t.kind = (mode_reg == M_LT) ? K_SHL : K_SHR;
                        push_data.toks[0] = t;
                        n = 2'd1;
                        taken = 1'b1;
                        mode_next = M_IDLE;
                    end
                M_SLASH:
                    if (char_code == CH_SLASH)
                    begin
                        taken = 1'b1;
                        mode_next = M_COMMENT;
                    end
                M_COMMENT:
                    if (char_code == CH_LF)
                        cm = M_IDLE;
                    else
                        taken = 1'b1;
                M_STRING:
                begin
                    taken = 1'b1;
                    if (char_code == CH_QUOTE)
                    begin
                        t.kind = K_STRING;
                        push_data.toks[0] = t;
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (char_code == CH_LF)
                        line_next = sat_inc(line_reg);
                end
                M_INT:
                    if (digit_char(char_code))
                        taken = 1'b1;
                    else if (char_code == CH_DOT)
                    begin
                        taken = 1'b1;
                        mode_next = M_DOT;
                    end
                M_DOT:
                    if (digit_char(char_code))
                    begin
                        taken = 1'b1;
                        mode_next = M_FRAC;
                    end
                M_FRAC:
                    taken = digit_char(char_code);
                M_WORD:
                    if (word_char(char_code) || digit_char(char_code))
                    begin
                        taken = 1'b1;
                        wr_en = (wlen_reg < WLEN_WIDTH'(KEYWORD_CHARS));
                        if (wlen_reg <= WLEN_WIDTH'(KEYWORD_CHARS))
                            wlen_next = wlen_reg + 1'b1;
                    end
                default: ;
            endcase

            if (!taken)
            begin
                t.epos = 16'(p);
                unique case (cm)
                    M_BANG, M_EQ, M_LT, M_GT, M_SLASH, M_INT, M_FRAC, M_WORD:
                    begin
                        unique case (cm)
                            M_BANG:  t.kind = K_BANG;
                            M_EQ:    t.kind = K_EQ;
                            M_LT:    t.kind = K_LT;
                            M_GT:    t.kind = K_GT;
                            M_SLASH: t.kind = K_SLASH;
                            M_WORD:  t.kind = word_kind;
                            default: t.kind = K_NUMBER;
                        endcase
                        push_data.toks[0] = t;
                        n = 2'd1;
                    end
                    M_DOT:
                    begin
                        t.epos = 16'(dotp);
                        t.kind = K_NUMBER;
                        push_data.toks[0] = t;
                        t.spos = 16'(dotp);
                        t.epos = 16'(p);
                        t.kind = K_DOT;
                        push_data.toks[1] = t;
                        n = 2'd2;
                    end
                    default: ;
                endcase
                mode_next   = M_IDLE;
                tstart_next = p;
                t           = '0;
                t.line      = 16'(line_reg);
                t.spos      = 16'(p);
                t.epos      = 16'(e);
                if (hit)
                begin
                    t.kind = sk;
                    push_data.toks[n] = t;
                    n = n + 2'd1;
                end
                else
                begin
                    priority case (1'b1)
                        char_code == CH_BANG:  mode_next = M_BANG;
                        char_code == CH_EQ:    mode_next = M_EQ;
                        char_code == CH_LT:    mode_next = M_LT;
                        char_code == CH_GT:    mode_next = M_GT;
                        char_code == CH_SLASH: mode_next = M_SLASH;
                        char_code == CH_QUOTE: mode_next = M_STRING;
                        char_code == CH_SPACE || char_code == CH_CR
                            || char_code == CH_TAB: ;
                        char_code == CH_LF:    line_next = sat_inc(line_reg);
                        digit_char(char_code): mode_next = M_INT;
                        word_char(char_code):
                        begin
                            mode_next = M_WORD;
                            wr_en     = 1'b1;
                            wr_idx    = '0;
                            wlen_next = WLEN_WIDTH'(1);
                        end
                        default:
                        begin
                            t.kind = K_ERROR;
                            t.err  = E_UNEXPECTED;
                            t.bad  = char_code;
                            push_data.toks[n] = t;
                            n = n + 2'd1;
                        end
                    endcase
                end
            end
            pos_next = e;
        end
        push_data.cnt = n;
    end

    assign push = accept && (push_data.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            tstart_reg <= '0;
            pos_reg    <= '0;
            line_reg   <= POS_WIDTH'(1);
            wlen_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            tstart_reg <= tstart_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            wlen_reg   <= wlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en && !kind)
            wbytes_reg[wr_idx[$clog2(KEYWORD_CHARS)-1:0]] <= char_code;
    end

endmodule

// ----- hdl/slt_queue.sv -----
module slt_queue
    import slt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t pop_data
);

    entry_t                mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wptr_reg, rptr_reg;
    logic [QPTR_WIDTH:0]   cnt_reg;

    assign full     = (cnt_reg == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_WIDTH+1)'(push) - (QPTR_WIDTH+1)'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> push_data.cnt != 2'd0)
        else $error("empty entry pushed");

endmodule

// ----- hdl/slt_back.sv -----
module slt_back
    import slt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  entry_t      q_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [15:0] start_pos,
    output logic [15:0] end_pos,
    output logic [15:0] line_number,
    output logic [1:0]  error_code,
    output logic [7:0]  bad_char,
    output logic        last
);

    entry_t     cur_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       done;
    tok_t       t;

    assign t           = cur_reg.toks[idx_reg];
    assign last        = (idx_reg == cur_reg.cnt - 2'd1);
    assign done        = valid_reg && !out_stall && last;
    assign pop         = (!valid_reg || done) && !q_empty;
    assign out_valid   = valid_reg;
    assign token_kind  = t.kind;
    assign start_pos   = t.spos;
    assign end_pos     = t.epos;
    assign line_number = t.line;
    assign error_code  = t.err;
    assign bad_char    = t.bad;

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (done)
            valid_reg <= 1'b0;
        else if (valid_reg && !out_stall)
            idx_reg <= idx_reg + 2'd1;
    end

    assert property (@(posedge clk) disable iff (!rst_n) valid_reg |-> idx_reg < cur_reg.cnt)
        else $error("word index past entry count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_stall && !last) |=> valid_reg)
        else $error("entry dropped before last word");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_stall && !last) |=> idx_reg == $past(idx_reg) + 2'd1)
        else $error("word index did not advance");

endmodule

// ----- hdl/script_lexer_tokenizer_top.sv -----
// streaming lexer: one source byte (kind 0) or end marker (kind 1) per input word
// input channel: in_valid / in_stall with kind and char_code
// output channel: out_valid / out_stall, one token per word, last marks the
//   final token caused by one input word
// front classifies a byte in the cycle it is accepted and pushes up to three
//   tokens as one entry into a four-entry queue; the back streams them out
// each entry is written into the queue and then popped into the back's entry register
// throughput: one byte per cycle while each byte yields at most one token and
//   the receiver does not stall; an entry of n tokens leaves as n output words
// in_stall rises only when the queue is full
// when the receiver stalls, the current token holds and the queue fills
// reset clears the scan state (position 0, line 1) and empties the queue;
//   the end marker returns the scanner to the same state
module script_lexer_tokenizer_top
    import slt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [15:0] start_pos,
    output logic [15:0] end_pos,
    output logic [15:0] line_number,
    output logic [1:0]  error_code,
    output logic [7:0]  bad_char,
    output logic        last
);

    logic   push, pop, q_full, q_empty;
    entry_t push_data, pop_data;

    slt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .char_code (char_code),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    slt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    slt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_kind  (token_kind),
        .start_pos   (start_pos),
        .end_pos     (end_pos),
        .line_number (line_number),
        .error_code  (error_code),
        .bad_char    (bad_char),
        .last        (last)
    );

endmodule

// ----- tb/script_lexer_tokenizer_top_tb.sv -----
`timescale 1ns / 100ps

module script_lexer_tokenizer_top_tb
    import slt_pkg::*;
();

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_WORDS = 220;
    localparam int STR_LINES = 4;
    localparam int DIR_ROWS = 24;

    localparam logic [5:0] TK_LPAREN = 6'd0;
    localparam logic [5:0] TK_PIPE = 6'd16;
    localparam logic IN_CHAR = 1'b0;
    localparam logic IN_END = 1'b1;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] spos;
        logic [15:0] epos;
        logic [15:0] line;
        logic [1:0]  err;
        logic [7:0]  bad;
        logic        last;
    } tok_rec_t;

    typedef struct packed {
        logic     k;
        logic [7:0] c;
        logic     typed;
        tok_rec_t t;
    } dir_row_t;

    typedef struct packed {
        logic       k;
        logic [7:0] c;
    } src_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic [7:0]  bad_char;
    logic        last;

    script_lexer_tokenizer_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .char_code(char_code),
        .out_valid(out_valid), .out_stall(out_stall), .token_kind(token_kind),
        .start_pos(start_pos), .end_pos(end_pos), .line_number(line_number),
        .error_code(error_code), .bad_char(bad_char), .last(last)
    );

    // scanner mirror
    logic [3:0]  scan_mode;
    logic [15:0] tok_start;
    logic [15:0] pos;
    logic [15:0] line_cnt;
    logic [7:0]  wbytes [KEYWORD_CHARS];
    logic [3:0]  wlen;

    tok_rec_t  step_toks [$];
    tok_rec_t  token_q [$];
    src_word_t src_q [$];
    int        mismatches;
    int        cycles;
    bit        in_quiet;
    bit        out_quiet;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{IN_CHAR, 8'h28, 1'b1, '{TK_LPAREN, 16'd0, 16'd1, 16'd1, E_NONE, 8'h00, 1'b1}},
        '{IN_CHAR, 8'h00, 1'b1, '{K_ERROR, 16'd1, 16'd2, 16'd1, E_UNEXPECTED, 8'h00, 1'b1}},
        '{IN_CHAR, 8'hff, 1'b1, '{K_ERROR, 16'd2, 16'd3, 16'd1, E_UNEXPECTED, 8'hff, 1'b1}},
        '{IN_CHAR, CH_BANG, 1'b0, '0},
        '{IN_CHAR, CH_EQ, 1'b0, '0},
        '{IN_CHAR, CH_LT, 1'b0, '0},
        '{IN_CHAR, CH_LT, 1'b0, '0},
        '{IN_CHAR, CH_GT, 1'b0, '0},
        '{IN_CHAR, CH_EQ, 1'b0, '0},
        '{IN_CHAR, CH_SLASH, 1'b0, '0},
        '{IN_CHAR, CH_SLASH, 1'b0, '0},
        '{IN_CHAR, 8'h78, 1'b0, '0},
        '{IN_CHAR, CH_LF, 1'b0, '0},
        '{IN_CHAR, 8'h31, 1'b0, '0},
        '{IN_CHAR, CH_DOT, 1'b0, '0},
        '{IN_CHAR, 8'h35, 1'b0, '0},
        '{IN_CHAR, CH_QUOTE, 1'b0, '0},
        '{IN_CHAR, CH_LF, 1'b0, '0},
        '{IN_END, 8'h00, 1'b0, '0},
        '{IN_CHAR, 8'h39, 1'b0, '0},
        '{IN_CHAR, CH_DOT, 1'b0, '0},
        '{IN_END, 8'hff, 1'b0, '0},
        '{IN_CHAR, 8'h7c, 1'b1, '{TK_PIPE, 16'd0, 16'd1, 16'd1, E_NONE, 8'h00, 1'b1}},
        '{IN_CHAR, 8'h80, 1'b1, '{K_ERROR, 16'd1, 16'd2, 16'd1, E_UNEXPECTED, 8'h80, 1'b1}}
    };

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == POS_MAX) ? v : v + 16'd1;
    endfunction

    function automatic bit is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alp(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    task automatic emit(input logic [5:0] tk, input logic [15:0] s, input logic [15:0] e,
                        input logic [1:0] er, input logic [7:0] bd);
        tok_rec_t r;
        r = '{tk, s, e, line_cnt, er, bd, 1'b0};
        if (step_toks.size() < 3)
            step_toks.insert(step_toks.size(), r);
    endtask

    function automatic logic [5:0] word_class();
        bit hit;
        if (wlen > KEYWORD_CHARS)
            return K_IDENT;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (KW_LEN[k] == wlen)
            begin
                hit = 1'b1;
                for (int i = 0; i < wlen; i++)
                    if (wbytes[i] != KW_TEXT[k][8*(wlen-1-i) +: 8])
                        hit = 1'b0;
                if (hit)
                    return K_KW0 + 6'(k);
            end
        end
        return K_IDENT;
    endfunction

    task automatic add_wbyte(input logic [7:0] c);
        if (wlen < KEYWORD_CHARS)
            wbytes[wlen[2:0]] = c;
        if (wlen <= KEYWORD_CHARS)
            wlen = wlen + 4'd1;
    endtask

    task automatic close_token(input logic [15:0] e, input bit at_end);
        logic [15:0] dot;
        case (scan_mode)
            M_BANG:   emit(K_BANG, tok_start, e, E_NONE, 8'h00);
            M_EQ:     emit(K_EQ, tok_start, e, E_NONE, 8'h00);
            M_LT:     emit(K_LT, tok_start, e, E_NONE, 8'h00);
            M_GT:     emit(K_GT, tok_start, e, E_NONE, 8'h00);
            M_SLASH:  emit(K_SLASH, tok_start, e, E_NONE, 8'h00);
            M_STRING: if (at_end) emit(K_ERROR, tok_start, e, E_UNTERM, 8'h00);
            M_INT, M_FRAC: emit(K_NUMBER, tok_start, e, E_NONE, 8'h00);
            M_DOT:
            begin
                dot = (e > 0) ? e - 16'd1 : 16'd0;
                emit(K_NUMBER, tok_start, dot, E_NONE, 8'h00);
                emit(K_DOT, dot, e, E_NONE, 8'h00);
            end
            M_WORD:   emit(word_class(), tok_start, e, E_NONE, 8'h00);
            default: ;
        endcase
        scan_mode = M_IDLE;
    endtask

    task automatic extend_token(input logic [7:0] c, input logic [15:0] p, output bit took);
        logic [15:0] e;
        e = sat_inc(p);
        took = 1'b1;
        case (scan_mode)
            M_BANG, M_EQ:
                if (c == CH_EQ)
                begin
                    emit(scan_mode == M_BANG ? K_BANG_EQ : K_EQ_EQ, tok_start, e, E_NONE, 8'h00);
                    scan_mode = M_IDLE;
                end
                else
                    took = 1'b0;
            M_LT, M_GT:
                if (c == CH_EQ)
                begin
                    emit(scan_mode == M_LT ? K_LT_EQ : K_GT_EQ, tok_start, e, E_NONE, 8'h00);
                    scan_mode = M_IDLE;
                end
                else if (c == (scan_mode == M_LT ? CH_LT : CH_GT))
                begin
                    emit(scan_mode == M_LT ? K_SHL : K_SHR, tok_start, e, E_NONE, 8'h00);
                    scan_mode = M_IDLE;
                end
                else
                    took = 1'b0;
            M_SLASH:
                if (c == CH_SLASH)
                    scan_mode = M_COMMENT;
                else
                    took = 1'b0;
            M_COMMENT:
                if (c == CH_LF)
                begin
                    scan_mode = M_IDLE;
                    took = 1'b0;
                end
            M_STRING:
                if (c == CH_QUOTE)
                begin
                    emit(K_STRING, tok_start, e, E_NONE, 8'h00);
                    scan_mode = M_IDLE;
                end
                else if (c == CH_LF)
                    line_cnt = sat_inc(line_cnt);
            M_INT:
                if (c == CH_DOT)
                    scan_mode = M_DOT;
                else if (!is_dig(c))
                    took = 1'b0;
            M_DOT:
                if (is_dig(c))
                    scan_mode = M_FRAC;
                else
                    took = 1'b0;
            M_FRAC:
                took = is_dig(c);
            M_WORD:
                if (is_alp(c) || is_dig(c))
                    add_wbyte(c);
                else
                    took = 1'b0;
            default:
                took = 1'b0;
        endcase
    endtask

    task automatic start_token(input logic [7:0] c, input logic [15:0] p);
        string singles;
        singles = "(){},.-+;*?:^~%&|";
        tok_start = p;
        for (int i = 0; i < singles.len(); i++)
            if (singles[i] == c)
            begin
                emit(6'(i), p, sat_inc(p), E_NONE, 8'h00);
                return;
            end
        if (c == CH_BANG)
            scan_mode = M_BANG;
        else if (c == CH_EQ)
            scan_mode = M_EQ;
        else if (c == CH_LT)
            scan_mode = M_LT;
        else if (c == CH_GT)
            scan_mode = M_GT;
        else if (c == CH_SLASH)
            scan_mode = M_SLASH;
        else if (c == CH_QUOTE)
            scan_mode = M_STRING;
        else if (c == CH_SPACE || c == CH_CR || c == CH_TAB)
            ;
        else if (c == CH_LF)
            line_cnt = sat_inc(line_cnt);
        else if (is_dig(c))
            scan_mode = M_INT;
        else if (is_alp(c))
        begin
            scan_mode = M_WORD;
            wlen = 4'd0;
            add_wbyte(c);
        end
        else
            emit(K_ERROR, p, sat_inc(p), E_UNEXPECTED, c);
    endtask

    task automatic clear_scanner();
        scan_mode = M_IDLE;
        tok_start = '0;
        pos = '0;
        line_cnt = 16'd1;
        wlen = 4'd0;
    endtask

    task automatic lex_word(input logic k, input logic [7:0] c);
        bit took;
        step_toks.delete();
        if (k == IN_END)
        begin
            close_token(pos, 1'b1);
            emit(K_END, pos, pos, E_NONE, 8'h00);
            clear_scanner();
        end
        else
        begin
            extend_token(c, pos, took);
            if (!took)
            begin
                close_token(pos, 1'b0);
                start_token(c, pos);
            end
            pos = sat_inc(pos);
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size()-1].last = 1'b1;
    endtask

    task automatic send_word(input logic k, input logic [7:0] c, input bit typed,
                             input tok_rec_t t);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lex_word(k, c);
        if (typed)
            token_q.insert(token_q.size(), t);
        else
            foreach (step_toks[i])
                token_q.insert(token_q.size(), step_toks[i]);
        if ($urandom_range(0, 39) == 0)
            in_quiet = !in_quiet;
    endtask

    task automatic add_src(input logic k, input logic [7:0] c);
        src_word_t w;
        w.k = k;
        w.c = c;
        src_q.insert(src_q.size(), w);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_src(IN_CHAR, s[i]);
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic build_random();
        string letters;
        string kw;
        int n;
        int sel;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        while (src_q.size() < RANDOM_WORDS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                add_src(IN_CHAR, 8'($urandom_range(0, 255)));
            else if (sel < 13)
                add_src(IN_END, 8'($urandom_range(0, 255)));
            else if (sel < 35)
            begin
                n = $urandom_range(0, NUM_KW - 1);
                kw = "";
                for (int i = int'(KW_LEN[n]) - 1; i >= 0; i--)
                    kw = {kw, string'(KW_TEXT[n][8*i +: 8])};
                push_text(kw);
                if ($urandom_range(0, 4) == 0)
                    add_src(IN_CHAR, pick({letters, "0123456789"}));
                add_src(IN_CHAR, pick(" \n(;"));
            end
            else if (sel < 50)
            begin
                add_src(IN_CHAR, pick(letters));
                n = $urandom_range(0, 11);
                repeat (n) add_src(IN_CHAR, pick({letters, "0123456789"}));
            end
            else if (sel < 62)
            begin
                repeat ($urandom_range(1, 4)) add_src(IN_CHAR, pick("0123456789"));
                if ($urandom_range(0, 1))
                begin
                    add_src(IN_CHAR, CH_DOT);
                    repeat ($urandom_range(0, 3))
                        add_src(IN_CHAR, pick("0123456789"));
                end
            end
            else if (sel < 80)
                add_src(IN_CHAR, pick("(){},.-+;*?:^~%&|!=<>/"));
            else if (sel < 86)
            begin
                add_src(IN_CHAR, CH_QUOTE);
                repeat ($urandom_range(0, 6)) add_src(IN_CHAR, pick({letters, " \n+1"}));
                if ($urandom_range(0, 3) != 0)
                    add_src(IN_CHAR, CH_QUOTE);
            end
            else if (sel < 90)
            begin
                push_text("//");
                repeat ($urandom_range(0, 5)) add_src(IN_CHAR, pick({letters, " \"9"}));
                add_src(IN_CHAR, CH_LF);
            end
            else
                add_src(IN_CHAR, pick(" \r\t\n"));
        end
        add_src(IN_END, 8'h00);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                ;
            else if (out_valid && !out_stall)
            begin
                if (token_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected token kind %0d start %0d end %0d",
                                 token_kind, start_pos, end_pos);
                end
                else if ({token_kind, start_pos, end_pos, line_number, error_code,
                          bad_char, last} !== token_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p got %0d %0d %0d %0d %0d %0h %0b",
                                 token_q[0], token_kind, start_pos, end_pos,
                                 line_number, error_code, bad_char, last);
                    void'(token_q.pop_front());
                end
                else
                    void'(token_q.pop_front());
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = out_quiet ? 0 : $urandom_range(0, 11);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
            if ($urandom_range(0, 39) == 0)
                out_quiet = !out_quiet;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = IN_CHAR;
        char_code = 8'h00;
        mismatches = 0;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        clear_scanner();
        for (int i = 0; i < KEYWORD_CHARS; i++)
            wbytes[i] = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_tab[i].k, dir_tab[i].c, dir_tab[i].typed, dir_tab[i].t);

        build_random();
        foreach (src_q[i])
            send_word(src_q[i].k, src_q[i].c, 1'b0, '0);

        // string across several lines, then a short mix back to back
        src_q.delete();
        add_src(IN_CHAR, CH_QUOTE);
        repeat (STR_LINES) add_src(IN_CHAR, CH_LF);
        push_text("\"(ab/");
        add_src(IN_CHAR, CH_LF);
        add_src(IN_CHAR, 8'h01);
        add_src(IN_END, 8'h00);
        push_text("x");
        add_src(IN_END, 8'h00);
        in_quiet = 1'b1;
        foreach (src_q[i])
            send_word(src_q[i].k, src_q[i].c, 1'b0, '0);
        in_valid <= 1'b0;

        while (token_q.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/slt_pkg.sv
hdl/slt_front.sv
hdl/slt_queue.sv
hdl/slt_back.sv
hdl/script_lexer_tokenizer_top.sv
tb/script_lexer_tokenizer_top_tb.sv
